FILE: hw/rtl/caf_pkg.sv
package caf_pkg;

  // Default number of fraction bits on the node and axis vectors
  localparam int MAG_FRAC_BITS_DEF = 15;

  // Internal fixed point: Q.24
  localparam int IQ = 24;
  localparam int QW = 30;
  typedef logic signed [QW-1:0] q_t;
  localparam logic signed [63:0] ONE_Q = 64'sd16777216;

  // mu0 as 1381687 / 2^40
  localparam logic [20:0] MU0_Q40 = 21'd1381687;

  // Input queue between front and back
  localparam int QDEPTH = 2;

  typedef enum logic [2:0] {
    REG_CUBIC_ON,
    REG_AXIS_A_X,
    REG_AXIS_A_Y,
    REG_AXIS_A_Z,
    REG_AXIS_B_X,
    REG_AXIS_B_Y,
    REG_AXIS_B_Z
  } reg_idx_t;

  typedef struct packed {
    logic               cubic_on;
    logic signed [15:0] axis_a_x;
    logic signed [15:0] axis_a_y;
    logic signed [15:0] axis_a_z;
    logic signed [15:0] axis_b_x;
    logic signed [15:0] axis_b_y;
    logic signed [15:0] axis_b_z;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_z;
    logic [21:0]        sat_mag;
    logic signed [24:0] k_first;
    logic signed [24:0] k_second;
    logic signed [24:0] k_third;
    logic [31:0]        node_weight;
    logic               active;
    logic               last_node;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROJ,
    ST_PROJ3,
    ST_SQ,
    ST_PROD,
    ST_PROD2,
    ST_PROD3,
    ST_EK,
    ST_DOT,
    ST_NUM,
    ST_EPROD,
    ST_DIV_SETUP,
    ST_DIV,
    ST_DIV_FIN,
    ST_DONE
  } state_t;

  // shift right with rounding half away from zero
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v, input int sh);
    logic [63:0] mag;
    logic [63:0] rounded;
    mag = v[63] ? (~v + 64'd1) : v;
    if (sh == 0) begin
      return v;
    end else if (sh >= 64) begin
      return '0;
    end
    rounded = (mag + (64'd1 << (sh - 1))) >> sh;
    return v[63] ? -$signed(rounded) : $signed(rounded);
  endfunction

  // bring a value with p fraction bits to Q.24
  function automatic logic signed [63:0] to_q(input logic signed [63:0] v, input int p);
    if (p >= IQ) begin
      return rnd_shr(v, p - IQ);
    end
    return v <<< (IQ - p);
  endfunction

  function automatic q_t clamp1(input logic signed [63:0] v);
    if (v > ONE_Q) begin
      return q_t'(ONE_Q);
    end else if (v < -ONE_Q) begin
      return q_t'(-ONE_Q);
    end
    return q_t'(v);
  endfunction

  function automatic q_t mulq(input q_t a, input q_t b);
    logic signed [2*QW-1:0] prod;
    prod = a * b;
    return q_t'(rnd_shr(64'(prod), IQ));
  endfunction

endpackage

FILE: hw/rtl/caf_regs.sv
module caf_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output caf_pkg::cfg_t       cfg
);

  caf_pkg::reg_idx_t idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign idx    = caf_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cubic_on <= 1'b0;
      cfg.axis_a_x <= 16'sh7FFF;
      cfg.axis_a_y <= '0;
      cfg.axis_a_z <= '0;
      cfg.axis_b_x <= '0;
      cfg.axis_b_y <= 16'sh7FFF;
      cfg.axis_b_z <= '0;
    end else if (wr_en) begin
      unique case (idx)
        caf_pkg::REG_CUBIC_ON: cfg.cubic_on <= pwdata[0];
        caf_pkg::REG_AXIS_A_X: cfg.axis_a_x <= pwdata[15:0];
        caf_pkg::REG_AXIS_A_Y: cfg.axis_a_y <= pwdata[15:0];
        caf_pkg::REG_AXIS_A_Z: cfg.axis_a_z <= pwdata[15:0];
        caf_pkg::REG_AXIS_B_X: cfg.axis_b_x <= pwdata[15:0];
        caf_pkg::REG_AXIS_B_Y: cfg.axis_b_y <= pwdata[15:0];
        caf_pkg::REG_AXIS_B_Z: cfg.axis_b_z <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      caf_pkg::REG_CUBIC_ON: prdata = {31'b0, cfg.cubic_on};
      caf_pkg::REG_AXIS_A_X: prdata = {16'b0, cfg.axis_a_x};
      caf_pkg::REG_AXIS_A_Y: prdata = {16'b0, cfg.axis_a_y};
      caf_pkg::REG_AXIS_A_Z: prdata = {16'b0, cfg.axis_a_z};
      caf_pkg::REG_AXIS_B_X: prdata = {16'b0, cfg.axis_b_x};
      caf_pkg::REG_AXIS_B_Y: prdata = {16'b0, cfg.axis_b_y};
      caf_pkg::REG_AXIS_B_Z: prdata = {16'b0, cfg.axis_b_z};
      default:               prdata = '0;
    endcase
  end

endmodule

FILE: hw/rtl/caf_front.sv
module caf_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            cubic_on,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [183:0]    s_axis_tdata,
  input  logic            s_axis_tuser,
  input  logic            s_axis_tlast,
  input  logic            q_pop,
  output logic            q_valid,
  output caf_pkg::item_t  q_item
);

  localparam int PW = $clog2(caf_pkg::QDEPTH);

  caf_pkg::item_t mem [caf_pkg::QDEPTH];
  caf_pkg::item_t in_item;
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [PW:0]    count;
  logic           push;
  logic           pop;

  // unpack and classify: only enabled, magnetic nodes need the arithmetic
  always_comb begin
    in_item.mag_x       = s_axis_tdata[15:0];
    in_item.mag_y       = s_axis_tdata[31:16];
    in_item.mag_z       = s_axis_tdata[47:32];
    in_item.sat_mag     = s_axis_tdata[69:48];
    in_item.k_first     = s_axis_tdata[94:70];
    in_item.k_second    = s_axis_tdata[119:95];
    in_item.k_third     = s_axis_tdata[144:120];
    in_item.node_weight = s_axis_tdata[176:145];
    in_item.active      = cubic_on & s_axis_tuser;
    in_item.last_node   = s_axis_tlast;
  end

  assign s_axis_tready = (count != (PW+1)'(caf_pkg::QDEPTH));
  assign push          = s_axis_tvalid & s_axis_tready;
  assign q_valid       = (count != '0);
  assign pop           = q_pop & q_valid;
  assign q_item        = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/caf_back.sv
module caf_back #(
  parameter int MAG_FRAC_BITS = caf_pkg::MAG_FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  caf_pkg::cfg_t   cfg,
  input  logic            q_valid,
  input  caf_pkg::item_t  q_item,
  output logic            q_pop,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [159:0]    m_axis_tdata,
  output logic            m_axis_tlast
);

  localparam int F = MAG_FRAC_BITS;
  localparam int QW = caf_pkg::QW;

  caf_pkg::state_t state, state_next;
  caf_pkg::item_t  item;

  // pipeline of the node computation
  logic signed [32:0] ce [3];
  caf_pkg::q_t        m [3];
  caf_pkg::q_t        cax [3][3];
  caf_pkg::q_t        s [3];
  caf_pkg::q_t        t12, t23, t13, sigma, s123, sig2;
  caf_pkg::q_t        p1 [3];
  caf_pkg::q_t        u [3];
  caf_pkg::q_t        p2 [3];
  caf_pkg::q_t        p3 [3];
  caf_pkg::q_t        r [3][3];
  logic signed [54:0] ek1, ek2, ek3;
  logic signed [41:0] e8;
  logic signed [58:0] plo, phi;
  logic [42:0]        d;
  logic signed [57:0] n [3];
  logic [1:0]         term;
  logic [4:0]         bit_cnt;

  // divider lanes
  logic               neg [3];
  logic               zero [3];
  logic               sat [3];
  logic [42:0]        rem [3];
  logic [31:0]        xlo [3];
  logic [31:0]        quo [3];

  logic signed [63:0] acc;
  logic signed [63:0] energy_sum;
  logic signed [31:0] fld [3];
  logic               out_load;

  // combinational datapath terms
  logic signed [15:0]      ax [3];
  logic signed [15:0]      bx [3];
  logic signed [15:0]      mv [3];
  logic signed [31:0]      xa [3];
  logic signed [31:0]      xb [3];
  logic signed [31:0]      pa [3];
  logic signed [31:0]      pb [3];
  logic signed [48:0]      pc [3];
  caf_pkg::q_t             psel [3];
  logic signed [2*QW-1:0]  dp [3][3];
  logic signed [54:0]      nk1 [3];
  logic signed [54:0]      nk2 [3];
  logic signed [54:0]      nk3 [3];
  logic [56:0]             magv [3];
  logic [72:0]             xv [3];
  logic [43:0]             rsh [3];
  logic                    ge [3];
  logic [31:0]             lim [3];
  logic [31:0]             qv [3];

  always_comb begin
    ax = '{cfg.axis_a_x, cfg.axis_a_y, cfg.axis_a_z};
    bx = '{cfg.axis_b_x, cfg.axis_b_y, cfg.axis_b_z};
    mv = '{item.mag_x, item.mag_y, item.mag_z};
    xa[0] = ax[1] * bx[2];
    xb[0] = ax[2] * bx[1];
    xa[1] = ax[2] * bx[0];
    xb[1] = ax[0] * bx[2];
    xa[2] = ax[0] * bx[1];
    xb[2] = ax[1] * bx[0];
    unique case (term)
      2'd0:    psel = p1;
      2'd1:    psel = p2;
      default: psel = p3;
    endcase
    for (int i = 0; i < 3; i++) begin
      pa[i]  = mv[i] * ax[i];
      pb[i]  = mv[i] * bx[i];
      pc[i]  = mv[i] * ce[i];
      for (int j = 0; j < 3; j++) begin
        dp[i][j] = psel[j] * cax[j][i];
      end
      nk1[i] = item.k_first * r[0][i];
      nk2[i] = item.k_second * r[1][i];
      nk3[i] = item.k_third * r[2][i];
      magv[i] = n[i][57] ? 57'(-n[i]) : 57'(n[i]);
      xv[i]   = {magv[i], 16'b0} + 73'(d >> 1);
      rsh[i]  = {rem[i], xlo[i][31]};
      ge[i]   = (rsh[i] >= {1'b0, d});
      lim[i]  = neg[i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      if (zero[i]) begin
        qv[i] = '0;
      end else if (sat[i] || (quo[i] > lim[i])) begin
        qv[i] = lim[i];
      end else begin
        qv[i] = quo[i];
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      caf_pkg::ST_IDLE: begin
        if (q_valid) begin
          state_next = q_item.active ? caf_pkg::ST_PROJ : caf_pkg::ST_DONE;
        end
      end
      caf_pkg::ST_PROJ:      state_next = caf_pkg::ST_PROJ3;
      caf_pkg::ST_PROJ3:     state_next = caf_pkg::ST_SQ;
      caf_pkg::ST_SQ:        state_next = caf_pkg::ST_PROD;
      caf_pkg::ST_PROD:      state_next = caf_pkg::ST_PROD2;
      caf_pkg::ST_PROD2:     state_next = caf_pkg::ST_PROD3;
      caf_pkg::ST_PROD3:     state_next = caf_pkg::ST_EK;
      caf_pkg::ST_EK:        state_next = caf_pkg::ST_DOT;
      caf_pkg::ST_DOT: begin
        if (term == 2'd2) begin
          state_next = caf_pkg::ST_NUM;
        end
      end
      caf_pkg::ST_NUM:       state_next = caf_pkg::ST_EPROD;
      caf_pkg::ST_EPROD:     state_next = caf_pkg::ST_DIV_SETUP;
      caf_pkg::ST_DIV_SETUP: state_next = caf_pkg::ST_DIV;
      caf_pkg::ST_DIV: begin
        if (bit_cnt == 5'd31) begin
          state_next = caf_pkg::ST_DIV_FIN;
        end
      end
      caf_pkg::ST_DIV_FIN:   state_next = caf_pkg::ST_DONE;
      caf_pkg::ST_DONE: begin
        if (out_load) begin
          state_next = caf_pkg::ST_IDLE;
        end
      end
      default:               state_next = caf_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop    = 1'b0;
    out_load = 1'b0;
    unique case (state)
      caf_pkg::ST_IDLE: q_pop    = q_valid;
      caf_pkg::ST_DONE: out_load = !m_axis_tvalid || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= caf_pkg::ST_IDLE;
      acc           <= '0;
      m_axis_tvalid <= 1'b0;
      term          <= '0;
      bit_cnt       <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
        acc           <= item.last_node ? 64'sd0 : energy_sum;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      term    <= (state == caf_pkg::ST_DOT) ? term + 2'd1 : 2'd0;
      bit_cnt <= (state == caf_pkg::ST_DIV) ? bit_cnt + 5'd1 : 5'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {energy_sum, fld[2], fld[1], fld[0]};
      m_axis_tlast <= item.last_node;
    end
    unique case (state)
      caf_pkg::ST_IDLE: begin
        item       <= q_item;
        energy_sum <= acc;
        for (int i = 0; i < 3; i++) begin
          fld[i] <= '0;
        end
      end
      caf_pkg::ST_PROJ: begin
        for (int i = 0; i < 3; i++) begin
          ce[i] <= 33'(xa[i]) - 33'(xb[i]);
        end
        m[0] <= caf_pkg::clamp1(caf_pkg::to_q(64'(pa[0]) + 64'(pa[1]) + 64'(pa[2]), 2 * F));
        m[1] <= caf_pkg::clamp1(caf_pkg::to_q(64'(pb[0]) + 64'(pb[1]) + 64'(pb[2]), 2 * F));
        d    <= item.sat_mag * caf_pkg::MU0_Q40;
      end
      caf_pkg::ST_PROJ3: begin
        m[2] <= caf_pkg::clamp1(caf_pkg::to_q(64'(pc[0]) + 64'(pc[1]) + 64'(pc[2]), 3 * F));
        for (int i = 0; i < 3; i++) begin
          cax[0][i] <= caf_pkg::clamp1(caf_pkg::to_q(64'(ax[i]), F));
          cax[1][i] <= caf_pkg::clamp1(caf_pkg::to_q(64'(bx[i]), F));
          cax[2][i] <= caf_pkg::clamp1(caf_pkg::to_q(64'(ce[i]), 2 * F));
        end
      end
      caf_pkg::ST_SQ: begin
        for (int i = 0; i < 3; i++) begin
          s[i] <= caf_pkg::mulq(m[i], m[i]);
        end
      end
      caf_pkg::ST_PROD: begin
        t12   <= caf_pkg::mulq(s[0], s[1]);
        t23   <= caf_pkg::mulq(s[1], s[2]);
        t13   <= caf_pkg::mulq(s[0], s[2]);
        p1[0] <= caf_pkg::mulq(m[0], s[1] + s[2]);
        p1[1] <= caf_pkg::mulq(m[1], s[0] + s[2]);
        p1[2] <= caf_pkg::mulq(m[2], s[0] + s[1]);
        u[0]  <= caf_pkg::mulq(m[0], s[1]);
        u[1]  <= caf_pkg::mulq(m[1], s[0]);
        u[2]  <= caf_pkg::mulq(m[2], s[0]);
      end
      caf_pkg::ST_PROD2: begin
        sigma <= t12 + t23 + t13;
        p2[0] <= caf_pkg::mulq(u[0], s[2]);
        p2[1] <= caf_pkg::mulq(u[1], s[2]);
        p2[2] <= caf_pkg::mulq(u[2], s[1]);
        s123  <= caf_pkg::mulq(t12, s[2]);
      end
      caf_pkg::ST_PROD3: begin
        for (int i = 0; i < 3; i++) begin
          p3[i] <= caf_pkg::mulq(sigma, p1[i]);
        end
        sig2 <= caf_pkg::mulq(sigma, sigma);
        ek1  <= item.k_first * sigma;
        ek2  <= item.k_second * s123;
      end
      caf_pkg::ST_EK: begin
        ek3 <= item.k_third * sig2;
      end
      caf_pkg::ST_DOT: begin
        // one term (K1, K2 or K3 shape) per cycle, back to the world frame
        for (int i = 0; i < 3; i++) begin
          r[term][i] <= caf_pkg::q_t'(caf_pkg::rnd_shr(
            64'(dp[i][0]) + 64'(dp[i][1]) + 64'(dp[i][2]), caf_pkg::IQ));
        end
      end
      caf_pkg::ST_NUM: begin
        for (int i = 0; i < 3; i++) begin
          n[i] <= 58'(-((64'(nk1[i]) <<< 1) + (64'(nk2[i]) <<< 1) + (64'(nk3[i]) <<< 2)));
        end
        e8 <= 42'(caf_pkg::rnd_shr(64'(ek1) + 64'(ek2) + 64'(ek3), caf_pkg::IQ - 8));
      end
      caf_pkg::ST_EPROD: begin
        // weight split in halves keeps the products narrow
        plo <= e8 * $signed({1'b0, item.node_weight[15:0]});
        phi <= e8 * $signed({1'b0, item.node_weight[31:16]});
      end
      caf_pkg::ST_DIV_SETUP: begin
        energy_sum <= acc + 64'(plo) + (64'(phi) <<< 16);
        for (int i = 0; i < 3; i++) begin
          neg[i]  <= n[i][57];
          zero[i] <= (magv[i] == '0);
          sat[i]  <= (item.sat_mag == '0) || (75'(xv[i]) >= {d, 32'b0});
          rem[i]  <= 43'(xv[i][72:32]);
          xlo[i]  <= xv[i][31:0];
          quo[i]  <= '0;
        end
      end
      caf_pkg::ST_DIV: begin
        for (int i = 0; i < 3; i++) begin
          rem[i] <= ge[i] ? 43'(rsh[i] - {1'b0, d}) : 43'(rsh[i]);
          xlo[i] <= {xlo[i][30:0], 1'b0};
          quo[i] <= {quo[i][30:0], ge[i]};
        end
      end
      caf_pkg::ST_DIV_FIN: begin
        for (int i = 0; i < 3; i++) begin
          fld[i] <= neg[i] ? -$signed(qv[i]) : $signed(qv[i]);
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/cubic_anisotropy_field_unit.sv
// The back end handles one node at a time: an enabled magnetic node goes through projection,
//   cubic products, energy and the 32-step radix-2 divider, while a disabled or non-magnetic
//   node skips the arithmetic. A 2-entry queue takes input while the back end is busy.
// Reset (rst, synchronous, active high): registers to defaults, queue and output empty,
//   energy accumulator cleared.
module cubic_anisotropy_field_unit #(
  parameter int MAG_FRAC_BITS = caf_pkg::MAG_FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  // configuration
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  // node stream in
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // mag_x, mag_y, mag_z, sat_mag, k_first, k_second, k_third, node_weight, zero pad
  input  logic [183:0]  s_axis_tdata,
  input  logic          s_axis_tuser,   // magnetic
  input  logic          s_axis_tlast,   // last_node
  // field stream out
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [159:0]  m_axis_tdata,   // field_x, field_y, field_z, energy_total
  output logic          m_axis_tlast    // last_out
);

  caf_pkg::cfg_t  cfg;
  caf_pkg::item_t q_item;
  logic           q_valid;
  logic           q_pop;

  // Register file: enable and the two crystal axes
  caf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Front: takes each transfer, marks whether it needs the arithmetic, queues it
  caf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cubic_on      (cfg.cubic_on),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .q_pop         (q_pop),
    .q_valid       (q_valid),
    .q_item        (q_item)
  );

  // Back: projection, cubic terms, energy, division by mu0*Ms, output register
  caf_back #(
    .MAG_FRAC_BITS (MAG_FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int FRAC = 15;
  localparam int STALL_LIMIT = 3000;   // cycles with no transfer before giving up
  localparam int SETTLE = 60;          // a bit more than the worst node latency

  typedef struct packed {
    logic signed [15:0] mx;
    logic signed [15:0] my;
    logic signed [15:0] mz;
    logic [21:0]        ms;
    logic signed [24:0] k1;
    logic signed [24:0] k2;
    logic signed [24:0] k3;
    logic               mg;
    logic [31:0]        w;
    logic               last;
  } node_t;

  typedef struct packed {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] fz;
    logic signed [63:0] energy;
    logic               last;
  } field_t;

  // directed row: node plus "zero field, zero energy" as the known answer
  typedef struct packed {
    node_t n;
    logic  zero_ans;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [183:0] s_axis_tdata = '0;
  logic s_axis_tuser = 0;
  logic s_axis_tlast = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [159:0] m_axis_tdata;
  logic m_axis_tlast;

  cubic_anisotropy_field_unit dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // predictor copy of the registers and the accumulator
  logic        cubic_en;
  longint      axis_a[3];
  longint      axis_b[3];
  longint      energy_sum;

  field_t      field_q[$];
  bit          known_zero_q[$];
  int          errors = 0;
  int          src_idle = 0;
  int          snk_idle = 0;
  int          hold_cnt = 0;
  int          quiet_cycles = 0;

  // ---------------- fixed-point predictor ----------------
  function automatic longint rshr(longint v, int s);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : v;
    if (s == 0) return v;
    m = (m + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint as_q24(longint v, int p);
    if (p >= 24) return rshr(v, p - 24);
    return v * (longint'(1) << (24 - p));
  endfunction

  function automatic longint sat_unit(longint v);
    if (v > (longint'(1) << 24)) return longint'(1) << 24;
    if (v < -(longint'(1) << 24)) return -(longint'(1) << 24);
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return rshr(a * b, 24);
  endfunction

  // N / (Ms * mu0), rounded, saturated to 32 bits; Ms = 0 saturates by sign
  function automatic logic [31:0] h_from_num(longint n, logic [21:0] ms);
    longint unsigned mag, d, q, r, lim;
    mag = (n < 0) ? longint'(-n) : n;
    if (mag == 0) return '0;
    lim = (n < 0) ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (ms == 0) begin
      q = lim;
    end else begin
      d = longint'(ms) * 64'd1381687;
      q = mag / d;
      r = mag % d;
      if (q >= 64'h8000_0000) begin
        q = lim;
      end else begin
        q = (q << 16) + (((r << 16) + d / 2) / d);
        if (q > lim) q = lim;
      end
    end
    if (n < 0) q = -q;
    return q[31:0];
  endfunction

  function automatic field_t anisotropy_field(node_t n);
    field_t f;
    longint mv[3], ce[3], c1[3], c2[3], c3[3], p1[3], p2[3], p3[3], h[3];
    longint m1, m2, m3, s1, s2, s3, sg, r1, r2, r3, num, e;
    f = '0;
    mv[0] = n.mx; mv[1] = n.my; mv[2] = n.mz;
    if (cubic_en && n.mg) begin
      ce[0] = axis_a[1] * axis_b[2] - axis_a[2] * axis_b[1];
      ce[1] = axis_a[2] * axis_b[0] - axis_a[0] * axis_b[2];
      ce[2] = axis_a[0] * axis_b[1] - axis_a[1] * axis_b[0];
      for (int i = 0; i < 3; i++) begin
        c1[i] = sat_unit(as_q24(axis_a[i], FRAC));
        c2[i] = sat_unit(as_q24(axis_b[i], FRAC));
        c3[i] = sat_unit(as_q24(ce[i], 2 * FRAC));
      end
      m1 = sat_unit(as_q24(mv[0] * axis_a[0] + mv[1] * axis_a[1] + mv[2] * axis_a[2],
                           2 * FRAC));
      m2 = sat_unit(as_q24(mv[0] * axis_b[0] + mv[1] * axis_b[1] + mv[2] * axis_b[2],
                           2 * FRAC));
      m3 = sat_unit(as_q24(mv[0] * ce[0] + mv[1] * ce[1] + mv[2] * ce[2], 3 * FRAC));
      s1 = qmul(m1, m1);
      s2 = qmul(m2, m2);
      s3 = qmul(m3, m3);
      sg = qmul(s1, s2) + qmul(s2, s3) + qmul(s1, s3);
      p1[0] = qmul(m1, s2 + s3);
      p1[1] = qmul(m2, s1 + s3);
      p1[2] = qmul(m3, s1 + s2);
      p2[0] = qmul(qmul(m1, s2), s3);
      p2[1] = qmul(qmul(m2, s1), s3);
      p2[2] = qmul(qmul(m3, s1), s2);
      for (int i = 0; i < 3; i++) p3[i] = qmul(sg, p1[i]);
      for (int i = 0; i < 3; i++) begin
        r1 = rshr(p1[0] * c1[i] + p1[1] * c2[i] + p1[2] * c3[i], 24);
        r2 = rshr(p2[0] * c1[i] + p2[1] * c2[i] + p2[2] * c3[i], 24);
        r3 = rshr(p3[0] * c1[i] + p3[1] * c2[i] + p3[2] * c3[i], 24);
        num = -(2 * longint'(n.k1) * r1 + 2 * longint'(n.k2) * r2
                + 4 * longint'(n.k3) * r3);
        h[i] = h_from_num(num, n.ms);
      end
      f.fx = h[0][31:0];
      f.fy = h[1][31:0];
      f.fz = h[2][31:0];
      e = longint'(n.k1) * sg + longint'(n.k2) * qmul(qmul(s1, s2), s3)
          + longint'(n.k3) * qmul(sg, sg);
      energy_sum += rshr(e, 16) * longint'({32'd0, n.w});   // wraps mod 2^64
    end
    f.energy = energy_sum;
    f.last = n.last;
    if (n.last) energy_sum = 0;
    return f;
  endfunction

  // ---------------- configuration ----------------
  task automatic reg_write(caf_pkg::reg_idx_t idx, logic [15:0] val);
    @(negedge clk);
    psel = 1; pwrite = 1; penable = 0;
    paddr = {idx, 2'b00};
    pwdata = {16'd0, val};
    @(negedge clk);
    penable = 1;
    @(negedge clk);   // register taken at the edge just passed
    psel = 0; penable = 0; pwrite = 0;
    case (idx)
      caf_pkg::REG_CUBIC_ON: cubic_en = val[0];
      caf_pkg::REG_AXIS_A_X: axis_a[0] = $signed(val);
      caf_pkg::REG_AXIS_A_Y: axis_a[1] = $signed(val);
      caf_pkg::REG_AXIS_A_Z: axis_a[2] = $signed(val);
      caf_pkg::REG_AXIS_B_X: axis_b[0] = $signed(val);
      caf_pkg::REG_AXIS_B_Y: axis_b[1] = $signed(val);
      default:               axis_b[2] = $signed(val);
    endcase
  endtask

  task automatic set_axes(logic on, logic [15:0] ax, ay, az, bx, by, bz);
    reg_write(caf_pkg::REG_CUBIC_ON, {15'd0, on});
    reg_write(caf_pkg::REG_AXIS_A_X, ax);
    reg_write(caf_pkg::REG_AXIS_A_Y, ay);
    reg_write(caf_pkg::REG_AXIS_A_Z, az);
    reg_write(caf_pkg::REG_AXIS_B_X, bx);
    reg_write(caf_pkg::REG_AXIS_B_Y, by);
    reg_write(caf_pkg::REG_AXIS_B_Z, bz);
  endtask

  // wait for every outstanding field, then let the pipe settle
  task automatic drain();
    while (field_q.size() != 0 || known_zero_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // ---------------- node stream ----------------
  // called and returns at a falling edge
  task automatic send_node(node_t n, bit zero_ans);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid = 0;
      @(negedge clk);
    end
    known_zero_q.push_back(zero_ans);
    s_axis_tvalid = 1;
    s_axis_tdata = {7'd0, n.w, n.k3, n.k2, n.k1, n.ms, n.mz, n.my, n.mx};
    s_axis_tuser = n.mg;
    s_axis_tlast = n.last;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    s_axis_tvalid = 0;
  endtask

  function automatic node_t random_node();
    node_t n;
    int r;
    r = $urandom_range(99);
    if (r < 60) begin
      // near-unit vectors mostly, so the field stays out of saturation
      n.mx = $signed(16'($urandom_range(65535))) >>> $urandom_range(3);
      n.my = $signed(16'($urandom_range(65535))) >>> $urandom_range(3);
      n.mz = $signed(16'($urandom_range(65535))) >>> $urandom_range(3);
    end else begin
      n.mx = 16'($urandom); n.my = 16'($urandom); n.mz = 16'($urandom);
    end
    n.ms = ($urandom_range(3) == 0) ? 22'($urandom) : 22'($urandom_range(2000000, 50000));
    if ($urandom_range(40) == 0) n.ms = 0;
    n.k1 = 25'($urandom);
    n.k2 = 25'($urandom);
    n.k3 = 25'($urandom);
    if ($urandom_range(1)) begin
      n.k1 = n.k1 >>> 8; n.k2 = n.k2 >>> 8; n.k3 = n.k3 >>> 8;
    end
    n.mg = ($urandom_range(9) != 0);
    n.w = $urandom;
    n.last = ($urandom_range(19) == 0);
    return n;
  endfunction

  // receiver: random backpressure, or a long hold-off when asked
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      m_axis_tready = 0;
      hold_cnt = hold_cnt - 1;
    end else begin
      m_axis_tready = ($urandom_range(99) >= snk_idle);
    end
  end

  // monitor: predict on input transfer, check on output transfer
  always @(posedge clk) begin
    field_t want, got;
    bit zero_ans;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      node_t n;
      n.mx = s_axis_tdata[15:0];
      n.my = s_axis_tdata[31:16];
      n.mz = s_axis_tdata[47:32];
      n.ms = s_axis_tdata[69:48];
      n.k1 = s_axis_tdata[94:70];
      n.k2 = s_axis_tdata[119:95];
      n.k3 = s_axis_tdata[144:120];
      n.w = s_axis_tdata[176:145];
      n.mg = s_axis_tuser;
      n.last = s_axis_tlast;
      want = anisotropy_field(n);
      zero_ans = known_zero_q.pop_front();
      if (zero_ans) begin
        want = '0;
        want.last = n.last;
      end
      field_q.push_back(want);
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.fx = m_axis_tdata[31:0];
      got.fy = m_axis_tdata[63:32];
      got.fz = m_axis_tdata[95:64];
      got.energy = m_axis_tdata[159:96];
      got.last = m_axis_tlast;
      if (field_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer: %p", got);
      end else begin
        want = field_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: want fx=%0d fy=%0d fz=%0d e=%0d last=%0b",
                     want.fx, want.fy, want.fz, want.energy, want.last);
            $display("          got  fx=%0d fy=%0d fz=%0d e=%0d last=%0b",
                     got.fx, got.fy, got.fz, got.energy, got.last);
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic random_phase(int count, int src, int snk, int hold_at, bit pause_mid);
    src_idle = src;
    snk_idle = snk;
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_cnt = 400;   // lets the queue fill and stall the input
      if (pause_mid && i == count / 2) drain();
      send_node(random_node(), 0);
    end
    drain();
  endtask

  // directed nodes: extremes, disabled, non-magnetic, zero Ms, clamped vectors
  row_t rows[] = '{
    // block still disabled after reset
    '{'{16'sh7FFF, 16'sh0, 16'sh0, 22'd1000, 25'h0FFFFFF, 25'h0FFFFFF, 25'h0FFFFFF,
        1'b1, 32'hFFFF_FFFF, 1'b0}, 1'b1},
    '{'{16'sh8000, 16'sh8000, 16'sh8000, 22'h3FFFFF, 25'h1000000, 25'h1000000,
        25'h1000000, 1'b1, 32'hFFFF_FFFF, 1'b1}, 1'b1}
  };
  row_t rows_on[] = '{
    '{'{16'sh4000, 16'sh4000, 16'sh0, 22'd5000, 25'h0FFFFFF, 25'h0, 25'h0,
        1'b0, 32'hFFFF_FFFF, 1'b1}, 1'b1},
    '{'{16'sh7FFF, 16'sh0, 16'sh0, 22'd1000, 25'h0FFFFFF, 25'h0FFFFFF, 25'h0FFFFFF,
        1'b1, 32'd1000, 1'b0}, 1'b0},
    '{'{16'sh5A82, 16'sh5A82, 16'sh0, 22'd0, 25'h0FFFFFF, 25'h0, 25'h0,
        1'b1, 32'd7, 1'b0}, 1'b0},
    '{'{16'sh5A82, 16'sh5A82, 16'sh0, 22'd0, 25'h1000000, 25'h0, 25'h0,
        1'b1, 32'd7, 1'b0}, 1'b0},
    '{'{16'sh0, 16'sh0, 16'sh0, 22'd0, 25'h0FFFFFF, 25'h0FFFFFF, 25'h0FFFFFF,
        1'b1, 32'd1, 1'b0}, 1'b0},
    '{'{16'sh49E6, 16'sh49E6, 16'sh49E6, 22'h3FFFFF, 25'h0FFFFFF, 25'h1000000,
        25'h0FFFFFF, 1'b1, 32'hFFFF_FFFF, 1'b0}, 1'b0},
    '{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 22'd1, 25'h1000000, 25'h0FFFFFF,
        25'h1000000, 1'b1, 32'hFFFF_FFFF, 1'b0}, 1'b0},
    '{'{16'sh8000, 16'sh8000, 16'sh8000, 22'h3FFFFF, 25'h1000000, 25'h1000000,
        25'h1000000, 1'b1, 32'hFFFF_FFFF, 1'b0}, 1'b0},
    '{'{16'sh2000, 16'shE000, 16'sh6000, 22'd800000, 25'd4500000, 25'h1F00000,
        25'd20000, 1'b0, 32'd12345, 1'b0}, 1'b0},
    '{'{16'shE000, 16'sh6000, 16'sh2000, 22'd800000, 25'd4500000, 25'h1F00000,
        25'd20000, 1'b1, 32'd12345, 1'b1}, 1'b0}
  };

  initial begin
    cubic_en = 0;
    axis_a[0] = 32767; axis_a[1] = 0; axis_a[2] = 0;
    axis_b[0] = 0; axis_b[1] = 32767; axis_b[2] = 0;
    energy_sum = 0;
    repeat (5) @(negedge clk);
    rst = 0;

    foreach (rows[i]) send_node(rows[i].n, rows[i].zero_ans);
    drain();
    reg_write(caf_pkg::REG_CUBIC_ON, 16'd1);
    foreach (rows_on[i]) send_node(rows_on[i].n, rows_on[i].zero_ans);
    drain();

    // random part over several axis settings and idle patterns
    random_phase(110, 12, 63, -1, 1);
    set_axes(1, 16'h8000, 16'h0, 16'h0, 16'h0, 16'h8000, 16'h0);
    random_phase(110, 63, 12, -1, 0);
    set_axes(1, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
             16'($urandom), 16'($urandom));
    random_phase(110, 0, 0, 20, 0);
    set_axes(1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    random_phase(110, 12, 63, -1, 0);
    set_axes(1, 16'h5A82, 16'hA57E, 16'h0, 16'h0, 16'h0, 16'h7FFF);
    random_phase(90, 0, 0, -1, 0);
    reg_write(caf_pkg::REG_CUBIC_ON, 16'd0);
    random_phase(20, 63, 12, -1, 0);

    if (errors == 0 && field_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
